// ===== design/ltr_pkg.sv =====
// ----------------------------------------------------------------------------
// ltr_pkg: shared types and constants of the linear interpolation resampler
// Holds the sample and frame types, the command passed from front to back,
// the effective configuration and the state codes of the back end.
// ----------------------------------------------------------------------------
package ltr_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 16;
   localparam int WEIGHT_FRAC  = 15;
   localparam int RATE_W       = 19;
   localparam int PHASE_W      = 20;
   localparam int CH_W         = 3;
   localparam int NCH_W        = 4;
   localparam int MUL_UP_SHIFT = 3;
   localparam int PROD_W       = 33;

   localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(48000);
   localparam logic [NCH_W-1:0]  DEFAULT_NCH  = NCH_W'(2);

   localparam logic [1:0] REG_INPUT_RATE    = 2'd0;
   localparam logic [1:0] REG_OUTPUT_RATE   = 2'd1;
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [MAX_CHANNELS-1:0] frame_type;

   typedef enum logic [1:0] {
      CMD_BYPASS,
      CMD_FRAME,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type    kind;
      logic [CH_W-1:0] ch;
      logic            frame_done;
      logic            has_prev;
      frame_type       frame;
   } cmd_type;

   typedef struct packed {
      logic [RATE_W-1:0] rin;
      logic [RATE_W-1:0] rout;
      logic [NCH_W-1:0]  nch;
      logic              clear;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_EMIT
   } state_type;

endpackage

// ===== design/ltr_req_if.sv =====
// ----------------------------------------------------------------------------
// ltr_req_if: input channel of the resampler
// Valid/ready channel carrying an operation code and one audio sample.
// ----------------------------------------------------------------------------
interface ltr_req_if;
   logic                 valid;
   logic                 ready;
   logic                 operation;
   ltr_pkg::sample_type  sample;

   modport source (output valid, output operation, output sample, input ready);
   modport sink   (input valid, input operation, input sample, output ready);
endinterface

// ===== design/ltr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ltr_rsp_if: result channel of the resampler
// Valid/ready channel carrying one output sample with its channel and last.
// ----------------------------------------------------------------------------
interface ltr_rsp_if;
   logic                          valid;
   logic                          ready;
   ltr_pkg::sample_type           sample_out;
   logic [ltr_pkg::CH_W-1:0]      channel;
   logic                          last;

   modport source (output valid, output sample_out, output channel, output last,
                   input ready);
   modport sink   (input valid, input sample_out, input channel, input last,
                   output ready);
endinterface

// ===== design/ltr_front.sv =====
// ----------------------------------------------------------------------------
// ltr_front: input side of the resampler
// Holds configuration, collects the interleaved frame and issues commands.
// ----------------------------------------------------------------------------
module ltr_front (
   input  logic                        clock,
   input  logic                        reset,
   ltr_req_if.sink                     req_ch,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [ltr_pkg::RATE_W-1:0]  csr_wdata,
   input  logic                        q_full,
   output logic                        q_push,
   output ltr_pkg::cmd_type            q_cmd,
   output ltr_pkg::cfg_type            cfg
);

   logic [ltr_pkg::RATE_W-1:0] rin_ff, rin_in;
   logic [ltr_pkg::RATE_W-1:0] rout_ff, rout_in;
   logic [ltr_pkg::NCH_W-1:0]  nch_ff, nch_in;
   logic [ltr_pkg::CH_W-1:0]   pos_ff, pos_in;
   logic                       has_prev_ff, has_prev_in;
   ltr_pkg::frame_type         cur_ff, cur_in;

   logic [ltr_pkg::RATE_W-1:0]            rin_eff, rout_raw, rout_eff;
   logic [ltr_pkg::RATE_W+ltr_pkg::MUL_UP_SHIFT-1:0] cap;
   logic [ltr_pkg::NCH_W-1:0]             nch_eff;
   logic [ltr_pkg::CH_W-1:0]              pos;
   logic                                  done, accept, cfg_hit;

   always_comb begin
      rin_eff  = (rin_ff == '0) ? ltr_pkg::DEFAULT_RATE : rin_ff;
      rout_raw = (rout_ff == '0) ? ltr_pkg::DEFAULT_RATE : rout_ff;
      cap      = {rin_eff, {ltr_pkg::MUL_UP_SHIFT{1'b0}}};
      rout_eff = ({{ltr_pkg::MUL_UP_SHIFT{1'b0}}, rout_raw} > cap) ?
                 cap[ltr_pkg::RATE_W-1:0] : rout_raw;
      if (nch_ff == '0) begin
         nch_eff = ltr_pkg::NCH_W'(1);
      end else if (nch_ff > ltr_pkg::NCH_W'(ltr_pkg::MAX_CHANNELS)) begin
         nch_eff = ltr_pkg::NCH_W'(ltr_pkg::MAX_CHANNELS);
      end else begin
         nch_eff = nch_ff;
      end
   end

   assign cfg_hit = csr_we && (csr_index == ltr_pkg::REG_INPUT_RATE ||
                               csr_index == ltr_pkg::REG_OUTPUT_RATE ||
                               csr_index == ltr_pkg::REG_CHANNEL_COUNT);

   assign cfg.rin   = rin_eff;
   assign cfg.rout  = rout_eff;
   assign cfg.nch   = nch_eff;
   assign cfg.clear = cfg_hit;

   assign req_ch.ready = !q_full;
   assign accept       = req_ch.valid && !q_full;

   assign pos  = ({1'b0, pos_ff} >= nch_eff) ? '0 : pos_ff;
   assign done = ({1'b0, pos} + ltr_pkg::NCH_W'(1)) >= nch_eff;

   always_comb begin
      rin_in      = rin_ff;
      rout_in     = rout_ff;
      nch_in      = nch_ff;
      pos_in      = pos_ff;
      has_prev_in = has_prev_ff;
      cur_in      = cur_ff;
      q_push      = 1'b0;
      q_cmd.kind       = ltr_pkg::CMD_FRAME;
      q_cmd.ch         = pos;
      q_cmd.frame_done = done;
      q_cmd.has_prev   = has_prev_ff;
      q_cmd.frame      = cur_ff;
      q_cmd.frame[pos] = req_ch.sample;

      if (cfg_hit) begin
         case (csr_index)
            ltr_pkg::REG_INPUT_RATE:  rin_in  = csr_wdata;
            ltr_pkg::REG_OUTPUT_RATE: rout_in = csr_wdata;
            default:                  nch_in  = csr_wdata[ltr_pkg::NCH_W-1:0];
         endcase
         pos_in      = '0;
         has_prev_in = 1'b0;
      end else if (accept) begin
         if (req_ch.operation == ltr_pkg::OP_FLUSH) begin
            q_cmd.kind  = ltr_pkg::CMD_FLUSH;
            q_push      = 1'b1;
            pos_in      = '0;
            has_prev_in = 1'b0;
         end else begin
            cur_in = q_cmd.frame;
            if (rin_eff == rout_eff) begin
               q_cmd.kind = ltr_pkg::CMD_BYPASS;
               q_push     = 1'b1;
               if (done) begin
                  pos_in      = '0;
                  has_prev_in = 1'b1;
               end else begin
                  pos_in = pos + ltr_pkg::CH_W'(1);
               end
            end else if (done) begin
               q_push      = 1'b1;
               pos_in      = '0;
               has_prev_in = 1'b1;
            end else begin
               pos_in = pos + ltr_pkg::CH_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rin_ff      <= ltr_pkg::DEFAULT_RATE;
         rout_ff     <= ltr_pkg::DEFAULT_RATE;
         nch_ff      <= ltr_pkg::DEFAULT_NCH;
         pos_ff      <= '0;
         has_prev_ff <= 1'b0;
      end else begin
         rin_ff      <= rin_in;
         rout_ff     <= rout_in;
         nch_ff      <= nch_in;
         pos_ff      <= pos_in;
         has_prev_ff <= has_prev_in;
      end
      cur_ff <= cur_in;
   end

endmodule

// ===== design/ltr_fifo.sv =====
// ----------------------------------------------------------------------------
// ltr_fifo: two-entry command queue between front and back
// ----------------------------------------------------------------------------
module ltr_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ltr_pkg::cmd_type push_cmd,
   input  logic             pop,
   output ltr_pkg::cmd_type pop_cmd,
   output logic             full,
   output logic             empty
);

   ltr_pkg::cmd_type mem_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign pop_cmd = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? !wr_ff : wr_ff;
      rd_in  = pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== design/ltr_back.sv =====
// ----------------------------------------------------------------------------
// ltr_back: output side of the resampler
// Walks a frame's output positions, derives the weight with a serial divider
// and interpolates each channel into the output register, or passes bypass.
// ----------------------------------------------------------------------------
module ltr_back (
   input  logic             clock,
   input  logic             reset,
   input  ltr_pkg::cfg_type cfg,
   input  logic             q_empty,
   input  ltr_pkg::cmd_type q_cmd,
   output logic             q_pop,
   ltr_rsp_if.source        rsp_ch
);

   ltr_pkg::state_type              state_ff, state_in;
   ltr_pkg::cmd_type                cmd_ff, cmd_in;
   ltr_pkg::frame_type              prev_ff, prev_in;
   logic [ltr_pkg::PHASE_W-1:0]     phase_ff, phase_in;
   logic [ltr_pkg::RATE_W-1:0]      rem_ff, rem_in;
   logic [15:0]                     num_ff, num_in, q_ff, q_in;
   logic [3:0]                      cnt_ff, cnt_in;
   logic [ltr_pkg::WEIGHT_FRAC-1:0] t_ff, t_in;
   logic [ltr_pkg::CH_W-1:0]        ch_ff, ch_in;
   logic signed [ltr_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic                            out_valid_ff, out_valid_in;
   ltr_pkg::sample_type             out_sample_ff, out_sample_in;
   logic [ltr_pkg::CH_W-1:0]        out_ch_ff, out_ch_in;
   logic                            out_last_ff, out_last_in;

   logic                            out_free, lt, ge, ch_last, pos_last;
   logic [ltr_pkg::PHASE_W+ltr_pkg::WEIGHT_FRAC-1:0] num_full;
   logic [ltr_pkg::RATE_W:0]        trial;
   logic [ltr_pkg::PHASE_W:0]       phase_next;
   logic signed [ltr_pkg::SAMPLE_BITS:0] diff;
   logic signed [ltr_pkg::PROD_W-1:0]    rounded;
   logic signed [ltr_pkg::SAMPLE_BITS+2:0] sum;

   assign out_free   = !out_valid_ff || rsp_ch.ready;
   assign lt         = {1'b0, cfg.rout} > phase_ff;
   assign phase_next = {1'b0, phase_ff} + (ltr_pkg::PHASE_W+1)'(cfg.rin);
   assign pos_last   = phase_next >= (ltr_pkg::PHASE_W+1)'(cfg.rout);
   assign ch_last    = {1'b0, ch_ff} == (cfg.nch - ltr_pkg::NCH_W'(1));
   assign num_full   = {phase_ff, {ltr_pkg::WEIGHT_FRAC{1'b0}}} +
                       (ltr_pkg::PHASE_W+ltr_pkg::WEIGHT_FRAC)'(cfg.rout >> 1);
   assign trial      = {rem_ff, num_ff[15]};
   assign ge         = trial >= {1'b0, cfg.rout};
   assign diff       = (ltr_pkg::SAMPLE_BITS+1)'(cmd_ff.frame[ch_ff]) -
                       (ltr_pkg::SAMPLE_BITS+1)'(prev_ff[ch_ff]);
   assign rounded    = (prod_ff + ltr_pkg::PROD_W'(1 << (ltr_pkg::WEIGHT_FRAC - 1)))
                       >>> ltr_pkg::WEIGHT_FRAC;
   assign sum        = (ltr_pkg::SAMPLE_BITS+3)'(prev_ff[ch_ff]) +
                       rounded[ltr_pkg::SAMPLE_BITS+2:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ltr_pkg::ST_IDLE: begin
            if (!q_empty) state_in = ltr_pkg::ST_DISPATCH;
         end
         ltr_pkg::ST_DISPATCH: begin
            case (cmd_ff.kind)
               ltr_pkg::CMD_BYPASS: if (out_free) state_in = ltr_pkg::ST_IDLE;
               ltr_pkg::CMD_FRAME:  state_in = cmd_ff.has_prev ? ltr_pkg::ST_CHECK :
                                                                 ltr_pkg::ST_IDLE;
               default:             state_in = ltr_pkg::ST_IDLE;
            endcase
         end
         ltr_pkg::ST_CHECK: state_in = lt ? ltr_pkg::ST_DIV : ltr_pkg::ST_IDLE;
         ltr_pkg::ST_DIV: begin
            if (cnt_ff == 4'd15) state_in = ltr_pkg::ST_MUL;
         end
         ltr_pkg::ST_MUL: state_in = ltr_pkg::ST_EMIT;
         ltr_pkg::ST_EMIT: begin
            if (out_free) state_in = ch_last ? ltr_pkg::ST_CHECK : ltr_pkg::ST_MUL;
         end
         default: state_in = ltr_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop         = 1'b0;
      cmd_in        = cmd_ff;
      prev_in       = prev_ff;
      phase_in      = phase_ff;
      rem_in        = rem_ff;
      num_in        = num_ff;
      q_in          = q_ff;
      cnt_in        = cnt_ff;
      t_in          = t_ff;
      ch_in         = ch_ff;
      prod_in       = prod_ff;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_sample_in = out_sample_ff;
      out_ch_in     = out_ch_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         ltr_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
            end
         end
         ltr_pkg::ST_DISPATCH: begin
            case (cmd_ff.kind)
               ltr_pkg::CMD_BYPASS: begin
                  if (out_free) begin
                     out_valid_in  = 1'b1;
                     out_sample_in = cmd_ff.frame[cmd_ff.ch];
                     out_ch_in     = cmd_ff.ch;
                     out_last_in   = 1'b1;
                     if (cmd_ff.frame_done) begin
                        prev_in  = cmd_ff.frame;
                        phase_in = '0;
                     end
                  end
               end
               ltr_pkg::CMD_FRAME: begin
                  if (!cmd_ff.has_prev) prev_in = cmd_ff.frame;
               end
               default: phase_in = '0;
            endcase
         end
         ltr_pkg::ST_CHECK: begin
            if (lt) begin
               rem_in = ltr_pkg::RATE_W'(
                           num_full[ltr_pkg::PHASE_W+ltr_pkg::WEIGHT_FRAC-2:16]);
               num_in = num_full[15:0];
               cnt_in = '0;
            end else begin
               phase_in = phase_ff - ltr_pkg::PHASE_W'(cfg.rout);
               prev_in  = cmd_ff.frame;
            end
         end
         ltr_pkg::ST_DIV: begin
            rem_in = ge ? ltr_pkg::RATE_W'(trial - {1'b0, cfg.rout}) :
                          trial[ltr_pkg::RATE_W-1:0];
            num_in = {num_ff[14:0], 1'b0};
            q_in   = {q_ff[14:0], ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               t_in  = q_in[15] ? '1 : q_in[ltr_pkg::WEIGHT_FRAC-1:0];
               ch_in = '0;
            end
         end
         ltr_pkg::ST_MUL: begin
            prod_in = ltr_pkg::PROD_W'(diff) *
                      ltr_pkg::PROD_W'($signed({1'b0, t_ff}));
         end
         ltr_pkg::ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (sum > (ltr_pkg::SAMPLE_BITS+3)'(32767)) begin
                  out_sample_in = 16'sh7fff;
               end else if (sum < -(ltr_pkg::SAMPLE_BITS+3)'(32768)) begin
                  out_sample_in = 16'sh8000;
               end else begin
                  out_sample_in = sum[ltr_pkg::SAMPLE_BITS-1:0];
               end
               out_ch_in   = ch_ff;
               out_last_in = ch_last && pos_last;
               if (ch_last) begin
                  phase_in = phase_next[ltr_pkg::PHASE_W-1:0];
               end else begin
                  ch_in = ch_ff + ltr_pkg::CH_W'(1);
               end
            end
         end
         default: ;
      endcase

      if (cfg.clear) phase_in = '0;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sample_out = out_sample_ff;
   assign rsp_ch.channel    = out_ch_ff;
   assign rsp_ch.last       = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ltr_pkg::ST_IDLE;
         phase_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
      cmd_ff        <= cmd_in;
      prev_ff       <= prev_in;
      rem_ff        <= rem_in;
      num_ff        <= num_in;
      q_ff          <= q_in;
      cnt_ff        <= cnt_in;
      t_ff          <= t_in;
      ch_ff         <= ch_in;
      prod_ff       <= prod_in;
      out_sample_ff <= out_sample_in;
      out_ch_ff     <= out_ch_in;
      out_last_ff   <= out_last_in;
   end

endmodule

// ===== design/linear_interp_resampler.sv =====
// ----------------------------------------------------------------------------
// linear_interp_resampler: linear interpolation sample rate converter
// Interleaved audio in, resampled interleaved audio out.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one transaction per input sample (operation = sample) or a
//   flush (operation = flush, clears history and phase). Samples arrive in
//   channel-interleaved order; a completed frame releases every output
//   position between the previous and the current frame, each as one
//   transaction per channel on rsp_ch, with last set on the final one.
//   csr_we/csr_index/csr_wdata write the input rate, output rate and channel
//   count; write only while the block is idle. Each such write clears history.
//   Equal effective rates pass each sample straight through with last set.
// Timing:
//   The front keeps accepting while the two-entry command queue has room; a
//   sample that completes a frame, a bypass sample or a flush is queued as a
//   command. Per output position the back runs the phase check and the
//   16-step serial weight divider (one quotient bit per cycle), then a
//   multiply step and a round-and-emit step per channel; the emit step waits
//   while the output register holds a result not yet taken.
// Reset and stall:
//   Synchronous reset restores default rates and two channels and empties the
//   queue. A stalled rsp_ch holds the output register; the back stops and the
//   queue then fills, dropping req_ch.ready.
// ----------------------------------------------------------------------------
module linear_interp_resampler (
   input  logic                       clock,
   input  logic                       reset,
   ltr_req_if.sink                    req_ch,
   ltr_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [ltr_pkg::RATE_W-1:0] csr_wdata
);

   ltr_pkg::cfg_type cfg;
   ltr_pkg::cmd_type push_cmd, pop_cmd;
   logic             push, pop, full, empty;

   // accept, frame collection, configuration
   ltr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (full),
      .q_push    (push),
      .q_cmd     (push_cmd),
      .cfg       (cfg)
   );

   // decouple front and back
   ltr_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .full     (full),
      .empty    (empty)
   );

   // weight division, interpolation, output register
   ltr_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (empty),
      .q_cmd   (pop_cmd),
      .q_pop   (pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

// ===== sim/resampler_checker.sv =====
// ----------------------------------------------------------------------------
// resampler_checker: output predictor and scoreboard of the resampler
// Follows register writes and accepted input transactions, computes the
// interpolated output samples and compares each result transaction in order.
// ----------------------------------------------------------------------------
module resampler_checker (
   input  logic                       clock,
   input  logic                       reset,
   ltr_req_if                         req,
   ltr_rsp_if                         rsp,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_index,
   input  logic [ltr_pkg::RATE_W-1:0] csr_wdata,
   output int                         pending,
   output int                         errors
);

   typedef struct {
      ltr_pkg::sample_type      value;
      logic [ltr_pkg::CH_W-1:0] ch;
      logic                     last;
   } resampled_type;

   resampled_type              resampled_q[$];
   logic [ltr_pkg::RATE_W-1:0] in_rate;
   logic [ltr_pkg::RATE_W-1:0] out_rate;
   logic [ltr_pkg::NCH_W-1:0]  chan_count;
   longint                     prev_frame[ltr_pkg::MAX_CHANNELS];
   longint                     cur_frame[ltr_pkg::MAX_CHANNELS];
   bit                         have_prev;
   int unsigned                phase_acc;
   int unsigned                chan_pos;
   int                         err_count;

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic void drop_history();
      foreach (prev_frame[i]) prev_frame[i] = 0;
      have_prev = 0;
      phase_acc = 0;
      chan_pos  = 0;
   endfunction

   function automatic longint blend(longint a, longint b, longint w);
      longint prod;
      prod = (b - a) * w + 64'sd16384;
      return clip16(a + (prod >>> ltr_pkg::WEIGHT_FRAC));
   endfunction

   function automatic void push_out(longint v, int unsigned c, bit lst);
      resampled_type r;
      r.value = ltr_pkg::sample_type'(v);
      r.ch    = c[ltr_pkg::CH_W-1:0];
      r.last  = lst;
      resampled_q.push_back(r);
   endfunction

   function automatic void resample_step(logic op, ltr_pkg::sample_type s);
      int unsigned nch, rin, rout, pos, ph;
      longint      w;
      int          n;
      nch  = (chan_count == 0) ? 1 :
             ((chan_count > ltr_pkg::MAX_CHANNELS) ? ltr_pkg::MAX_CHANNELS : chan_count);
      rin  = (in_rate == 0) ? 48000 : in_rate;
      rout = (out_rate == 0) ? 48000 : out_rate;
      n    = 0;
      if (rout > rin * 8) rout = rin * 8;
      if (op == ltr_pkg::OP_FLUSH) begin
         drop_history();
         return;
      end
      if (chan_pos >= nch) chan_pos = 0;
      pos = chan_pos;
      cur_frame[pos] = s;
      if (rin == rout) begin
         push_out(s, pos, 1'b1);
         if (pos + 1 >= nch) begin
            prev_frame = cur_frame;
            have_prev  = 1;
            phase_acc  = 0;
            chan_pos   = 0;
         end else begin
            chan_pos = pos + 1;
         end
         return;
      end
      if (pos + 1 < nch) begin
         chan_pos = pos + 1;
         return;
      end
      chan_pos = 0;
      if (have_prev) begin
         ph = phase_acc & 32'hFFFFF;
         while (ph < rout) begin
            w = ((longint'(ph) << ltr_pkg::WEIGHT_FRAC) + rout / 2) / rout;
            if (w > 32767) w = 32767;
            for (int c = 0; c < nch; c++) begin
               if (n < 64) begin
                  push_out(blend(prev_frame[c], cur_frame[c], w), c, 1'b0);
                  n++;
               end
            end
            ph += rin;
         end
         phase_acc = (ph - rout) & 32'hFFFFF;
      end
      prev_frame = cur_frame;
      have_prev  = 1;
      if (n > 0) resampled_q[resampled_q.size()-1].last = 1'b1;
   endfunction

   always @(posedge clock) begin
      resampled_type e;
      if (reset) begin
         in_rate    = ltr_pkg::DEFAULT_RATE;
         out_rate   = ltr_pkg::DEFAULT_RATE;
         chan_count = ltr_pkg::DEFAULT_NCH;
         foreach (cur_frame[i]) cur_frame[i] = 0;
         drop_history();
         resampled_q.delete();
         err_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               ltr_pkg::REG_INPUT_RATE: begin
                  in_rate = csr_wdata;
                  drop_history();
               end
               ltr_pkg::REG_OUTPUT_RATE: begin
                  out_rate = csr_wdata;
                  drop_history();
               end
               ltr_pkg::REG_CHANNEL_COUNT: begin
                  chan_count = csr_wdata[ltr_pkg::NCH_W-1:0];
                  drop_history();
               end
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (resampled_q.size() == 0) begin
               $error("unexpected result: sample_out %0d channel %0d last %0d",
                      rsp.sample_out, rsp.channel, rsp.last);
               err_count++;
            end else begin
               e = resampled_q.pop_front();
               if (rsp.sample_out !== e.value) begin
                  $error("sample_out: expected %0d actual %0d", e.value, rsp.sample_out);
                  err_count++;
               end
               if (rsp.channel !== e.ch) begin
                  $error("channel: expected %0d actual %0d", e.ch, rsp.channel);
                  err_count++;
               end
               if (rsp.last !== e.last) begin
                  $error("last: expected %0d actual %0d", e.last, rsp.last);
                  err_count++;
               end
            end
         end
         if (req.valid && req.ready) resample_step(req.operation, req.sample);
      end
      pending <= resampled_q.size();
      errors  <= err_count;
   end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: top level of the resampler simulation
// Drives sample and flush transactions through a series of rate and channel
// settings with random idling on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 400;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [1:0]                 csr_index = ltr_pkg::REG_INPUT_RATE;
   logic [ltr_pkg::RATE_W-1:0] csr_wdata = '0;
   int                         pending;
   int                         errors;
   int                         cycle_count = 0;
   int                         sent = 0;
   int                         send_idle_pct = 24;
   int                         recv_idle_pct = 51;
   int                         hold_token = 0;
   int                         hold_seen = 0;
   int                         hold_left = 0;

   ltr_req_if req_ch();
   ltr_rsp_if rsp_ch();

   linear_interp_resampler u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   resampler_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .pending   (pending),
      .errors    (errors)
   );

   always #1 clock = ~clock;

   // Watchdog: give up well past the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Result side: random back-pressure, plus a long hold whenever the
   // stimulus bumps hold_token, so the block fills and stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_seen != hold_token) begin
         hold_seen    <= hold_token;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Send one transaction; hold it until the block takes it. Ready depends
   // only on registered state, so its value mid-cycle is the one seen at the
   // next rising edge.
   task automatic send_item(logic op, ltr_pkg::sample_type s);
      logic taken;
      // Shift the idling mix as the run advances.
      if (sent < 123) begin
         send_idle_pct = 24;
         recv_idle_pct = 51;
      end else if (sent < 246) begin
         send_idle_pct = 51;
         recv_idle_pct = 24;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.sample    <= s;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end
      sent++;
   endtask

   // Drop valid and wait until every predicted result has come back,
   // then let the back end finish any frame that yields nothing.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   // Reprogram all three registers while the block is idle.
   task automatic program_rates(int unsigned rin, int unsigned rout, int unsigned nch);
      drain();
      csr_we    <= 1'b1;
      csr_index <= ltr_pkg::REG_INPUT_RATE;
      csr_wdata <= rin[ltr_pkg::RATE_W-1:0];
      @(posedge clock);
      csr_index <= ltr_pkg::REG_OUTPUT_RATE;
      csr_wdata <= rout[ltr_pkg::RATE_W-1:0];
      @(posedge clock);
      csr_index <= ltr_pkg::REG_CHANNEL_COUNT;
      csr_wdata <= nch[ltr_pkg::RATE_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic ltr_pkg::sample_type pick_sample();
      case ($urandom_range(9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return ltr_pkg::sample_type'($urandom_range(255)) - 16'sd128;
         default: return ltr_pkg::sample_type'($urandom);
      endcase
   endfunction

   // Mostly whole frames of random audio; now and then a flush or a
   // stray sample that breaks the frame alignment.
   task automatic random_audio(int count, int nch);
      int k;
      k = 0;
      while (k < count) begin
         if ($urandom_range(99) < 4) begin
            send_item(ltr_pkg::OP_FLUSH, '0);
            k++;
         end else if ($urandom_range(99) < 5) begin
            send_item(ltr_pkg::OP_SAMPLE, pick_sample());
            k++;
         end else begin
            for (int c = 0; c < nch; c++) send_item(ltr_pkg::OP_SAMPLE, pick_sample());
            k += nch;
         end
      end
   endtask

   initial begin
      req_ch.valid     <= 1'b0;
      req_ch.operation <= ltr_pkg::OP_SAMPLE;
      req_ch.sample    <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: equal rates, two channels, straight pass-through.
      send_item(ltr_pkg::OP_SAMPLE, 16'sh7FFF);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh8000);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh0000);
      send_item(ltr_pkg::OP_FLUSH, '0);
      send_item(ltr_pkg::OP_SAMPLE, 16'shFFFF);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh0001);
      random_audio(30, 2);

      // Mild upsampling, starting with full-swing frames.
      program_rates(44100, 48000, 2);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh8000);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh7FFF);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh7FFF);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh8000);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh0000);
      // Flush in the middle of a frame.
      send_item(ltr_pkg::OP_FLUSH, '0);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh1234);
      send_item(ltr_pkg::OP_SAMPLE, 16'shEDCC);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh7FFF);
      send_item(ltr_pkg::OP_SAMPLE, 16'sh8000);
      random_audio(30, 2);

      // Downsampling, channel count zero acts as one.
      program_rates(48000, 44100, 0);
      random_audio(40, 1);

      // Full 8x upsampling on eight channels; stall the result side long
      // enough that the input backs up.
      program_rates(48000, 384000, 8);
      hold_token++;
      random_audio(48, 8);
      drain();
      random_audio(16, 8);

      // Output rate past the cap, channel count above the maximum.
      program_rates(8000, 384000, 15);
      random_audio(40, 8);

      // Zero rates mean the default on both sides: pass-through again.
      program_rates(0, 0, 3);
      random_audio(30, 3);

      // Extreme downsampling: outputs are very sparse.
      program_rates(384000, 1, 4);
      random_audio(16, 4);

      // Zero output rate means the default; also try the unused index.
      program_rates(22050, 0, 5);
      csr_we    <= 1'b1;
      csr_index <= 2'd3;
      csr_wdata <= '1;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      random_audio(40, 5);

      program_rates(96000, 44100, 7);
      hold_token++;
      random_audio(50, 7);

      drain();
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/ltr_pkg.sv
design/ltr_req_if.sv
design/ltr_rsp_if.sv
design/ltr_front.sv
design/ltr_fifo.sv
design/ltr_back.sv
design/linear_interp_resampler.sv
sim/resampler_checker.sv
sim/testbench.sv
